// ===== rtl/sws_pkg.sv =====
`timescale 1ns / 1ps
package sws_pkg;
    localparam int HISTORY_DEPTH = 16;
    localparam int CHANNEL_COUNT = 8;
    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CH_W = 3;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int ADDR_W = $clog2(CHANNEL_COUNT * HISTORY_DEPTH);
    localparam int SUM_W = 16 + CNT_W;
    localparam int TREND_SCALE = 25600;
    localparam int TREND_MAX = 2147483647;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAST_RD,
        ST_LAST_WAIT,
        ST_PUSH,
        ST_SCAN_RD,
        ST_SCAN_ACC,
        ST_DIV_AVG,
        ST_DIV_TRD,
        ST_DONE
    } state_t;

    // request to the shared divider
    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [47:0] quotient;
    } div_rsp_t;
endpackage

// ===== rtl/sws_divider.sv =====
`timescale 1ns / 1ps
module sws_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  sws_pkg::div_req_t req,
    output sws_pkg::div_rsp_t rsp
);
    import sws_pkg::*;

    // restoring divider, one quotient bit per cycle
    logic [47:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[47]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[46:0], 1'b0};
            rem_next = trial;
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next    = trial - {1'b0, dsr_reg};
                quo_next[0] = 1'b1;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

// ===== rtl/sensor_window_statistics.sv =====
`timescale 1ns / 1ps
// Per-channel sliding window statistics.
// Input channel (in_valid/in_ready): channel, sample, reading_ok, clear_channel.
// Output channel (out_valid/out_ready): channel_out, average, maximum, trend_q8,
// stored_count, one result per request.
// A push to a valid channel stores a sample (or repeats the newest one on a
// failed reading) and then walks every stored sample of that channel, a read
// state and an accumulate state per sample through the history memory,
// accumulating sum, maximum and the old/recent window sums. The shared serial
// divider then computes the average and, when at least four samples are stored
// and the old window sum is nonzero, the trend. Clears and out-of-range
// channels skip the scan and the divider and go straight to the result.
// Requests are taken one at a time: in_ready is high only while the block is idle.
// Reset empties all channels at once (fill counts and write pointers cleared);
// the history memory itself is not cleared. A result waits in the output
// register until out_ready; the next request is taken once it has been sent.
module sensor_window_statistics (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          channel,
    input  logic [15:0]         sample,
    input  logic                reading_ok,
    input  logic                clear_channel,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          channel_out,
    output logic [15:0]         average,
    output logic [15:0]         maximum,
    output logic signed [31:0]  trend_q8,
    output logic [4:0]          stored_count
);
    import sws_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);

    state_t state_reg, state_next;

    logic [15:0] mem [CHANNEL_COUNT*HISTORY_DEPTH];
    logic [15:0] rd_data_reg;
    logic        wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [15:0] wr_data;

    logic [CNT_W-1:0] fill_reg [CHANNEL_COUNT];
    logic [PTR_W-1:0] wp_reg   [CHANNEL_COUNT];

    logic [CH_W-1:0]  ch_reg;
    logic [15:0]      smp_reg;
    logic             ok_reg;
    logic             clr_reg;
    logic             chv;
    logic [CH_W-1:0]  cidx;

    logic [CNT_W-1:0] n_reg, i_reg, i_next;
    logic [PTR_W-1:0] oldest_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [15:0]      max_reg;
    logic [17:0]      olds_reg, recs_reg;
    logic [CNT_W-1:0] w_reg;

    logic [15:0]      avg_reg;
    logic [31:0]      trd_reg;
    logic [CH_W-1:0]  och_reg;
    logic [4:0]       ocnt_reg;
    logic             ovalid_reg;

    div_req_t dreq;
    div_rsp_t drsp;
    logic     div_started_reg;

    sws_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .rsp  (drsp)
    );

    assign cidx = ch_reg;
    assign chv  = (32'(ch_reg) < CHANNEL_COUNT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !ovalid_reg)
                begin
                    state_next = ST_LAST_RD;
                end
            end
            ST_LAST_RD:
            begin
                if (!chv || clr_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_LAST_WAIT;
            end
            ST_LAST_WAIT: state_next = ST_PUSH;
            ST_PUSH:      state_next = ST_SCAN_RD;
            ST_SCAN_RD:   state_next = ST_SCAN_ACC;
            ST_SCAN_ACC:
            begin
                if (i_reg + 1'b1 >= n_reg)
                    state_next = ST_DIV_AVG;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_DIV_AVG:
            begin
                if (drsp.done)
                begin
                    if (n_reg >= CNT_W'(4) && olds_reg != '0)
                        state_next = ST_DIV_TRD;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_DIV_TRD:
            begin
                if (drsp.done)
                    state_next = ST_DONE;
            end
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE) && !ovalid_reg;
        wr_en    = 1'b0;
        wr_addr  = {cidx, wp_reg[cidx]};
        wr_data  = ok_reg ? smp_reg : ((fill_reg[cidx] != '0) ? rd_data_reg : 16'd0);
        rd_addr  = {cidx, wp_reg[cidx] - 1'b1};
        i_next   = i_reg;
        dreq     = '0;
        unique case (state_reg)
            ST_PUSH:
            begin
                wr_en  = 1'b1;
                i_next = '0;
            end
            ST_SCAN_RD: rd_addr = {cidx, oldest_reg + PTR_W'(i_reg)};
            ST_SCAN_ACC: i_next = i_reg + 1'b1;
            ST_DIV_AVG:
            begin
                dreq.start    = !div_started_reg;
                dreq.dividend = 48'(sum_reg);
                dreq.divisor  = 32'(n_reg);
            end
            ST_DIV_TRD:
            begin
                dreq.start = !div_started_reg;
                dreq.dividend = (recs_reg >= olds_reg)
                    ? 48'(recs_reg - olds_reg) * 48'(TREND_SCALE)
                    : 48'(olds_reg - recs_reg) * 48'(TREND_SCALE);
                dreq.divisor = 32'(olds_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ovalid_reg      <= 1'b0;
            div_started_reg <= 1'b0;
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                fill_reg[c] <= '0;
                wp_reg[c]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DIV_AVG || state_reg == ST_DIV_TRD)
                div_started_reg <= !drsp.done;
            else
                div_started_reg <= 1'b0;
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            if (state_reg == ST_DONE)
                ovalid_reg <= 1'b1;
            if (state_reg == ST_LAST_RD && chv && clr_reg)
            begin
                fill_reg[cidx] <= '0;
                wp_reg[cidx]   <= '0;
            end
            if (wr_en)
            begin
                wp_reg[cidx] <= wp_reg[cidx] + 1'b1;
                if (fill_reg[cidx] < DEPTH_C)
                    fill_reg[cidx] <= fill_reg[cidx] + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg  <= channel;
            smp_reg <= sample;
            ok_reg  <= reading_ok;
            clr_reg <= clear_channel;
            avg_reg <= '0;
            trd_reg <= '0;
            max_reg <= '0;
            sum_reg <= '0;
            olds_reg <= '0;
            recs_reg <= '0;
            n_reg   <= '0;
        end
        i_reg <= i_next;
        if (state_reg == ST_PUSH)
        begin
            n_reg <= (fill_reg[cidx] < DEPTH_C) ? fill_reg[cidx] + 1'b1 : fill_reg[cidx];
            oldest_reg <= wp_reg[cidx] + 1'b1
                - PTR_W'((fill_reg[cidx] < DEPTH_C) ? fill_reg[cidx] + 1'b1 : fill_reg[cidx]);
            w_reg <= ((fill_reg[cidx] < DEPTH_C ? fill_reg[cidx] + 1'b1 : fill_reg[cidx])
                >= CNT_W'(6)) ? CNT_W'(3)
                : ((fill_reg[cidx] < DEPTH_C ? fill_reg[cidx] + 1'b1 : fill_reg[cidx]) >> 1);
        end
        if (state_reg == ST_SCAN_ACC)
        begin
            sum_reg <= sum_reg + SUM_W'(rd_data_reg);
            if (rd_data_reg > max_reg)
                max_reg <= rd_data_reg;
            if (i_reg < w_reg)
                olds_reg <= olds_reg + 18'(rd_data_reg);
            if (i_reg >= n_reg - w_reg)
                recs_reg <= recs_reg + 18'(rd_data_reg);
        end
        if (state_reg == ST_DIV_AVG && drsp.done)
            avg_reg <= drsp.quotient[15:0];
        if (state_reg == ST_DIV_TRD && drsp.done)
        begin
            if (recs_reg < olds_reg)
                trd_reg <= 32'(-$signed({1'b0, drsp.quotient[31:0]}));
            else if (drsp.quotient > 48'(TREND_MAX))
                trd_reg <= 32'(TREND_MAX);
            else
                trd_reg <= drsp.quotient[31:0];
        end
        if (state_reg == ST_DONE)
        begin
            och_reg  <= ch_reg;
            ocnt_reg <= 5'(n_reg);
        end
    end

    assign out_valid    = ovalid_reg;
    assign channel_out  = och_reg;
    assign average      = avg_reg;
    assign maximum      = max_reg;
    assign trend_q8     = trd_reg;
    assign stored_count = ocnt_reg;
endmodule

// ===== rtl/sws_checker.sv =====
`timescale 1ns / 1ps
module sws_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] average,
    input logic [15:0] maximum,
    input logic signed [31:0] trend_q8,
    input logic [4:0]  stored_count
);
    import sws_pkg::*;

    a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("request taken while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average) && $stable(maximum))
        else $error("result changed while stalled");

    a_avg_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> average <= maximum) else $error("average above maximum");

    a_trend_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> trend_q8 >= -32'sd25600) else $error("trend below floor");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(stored_count) <= HISTORY_DEPTH) else $error("count too large");
endmodule

bind sensor_window_statistics sws_checker u_sws_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .average     (average),
    .maximum     (maximum),
    .trend_q8    (trend_q8),
    .stored_count(stored_count)
);

// ===== verif/sensor_window_statistics_test.sv =====
`timescale 1ns / 1ps
module sensor_window_statistics_test;
    import sws_pkg::*;

    typedef struct {
        logic [2:0]         ch;
        logic [15:0]        avg;
        logic [15:0]        mx;
        logic signed [31:0] trend;
        logic [4:0]         cnt;
    } stats_t;

    typedef struct {
        logic [2:0]         ch;
        logic [15:0]        smp;
        logic               ok;
        logic               clr;
        bit                 typed;
        logic [15:0]        avg;
        logic [15:0]        mx;
        logic signed [31:0] trend;
        logic [4:0]         cnt;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         channel = '0;
    logic [15:0]        sample = '0;
    logic               reading_ok = 1'b0;
    logic               clear_channel = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         channel_out;
    logic [15:0]        average;
    logic [15:0]        maximum;
    logic signed [31:0] trend_q8;
    logic [4:0]         stored_count;

    sensor_window_statistics u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .channel(channel), .sample(sample),
        .reading_ok(reading_ok), .clear_channel(clear_channel),
        .out_valid(out_valid), .out_ready(out_ready),
        .channel_out(channel_out), .average(average), .maximum(maximum),
        .trend_q8(trend_q8), .stored_count(stored_count)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [15:0] hist [CHANNEL_COUNT][HISTORY_DEPTH];
    int unsigned fill [CHANNEL_COUNT];
    int unsigned wptr [CHANNEL_COUNT];

    // expected results, ring of 64 entries
    stats_t exp_fifo [64];
    int     exp_wr = 0;
    int     exp_rd = 0;
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_off = 1'b0;

    function automatic stats_t window_stats(logic [2:0] ch, logic [15:0] smp,
                                            logic ok, logic clr);
        stats_t r;
        logic [15:0] v;
        int unsigned n, oldest, w, i;
        longint sum, olds, recents, q;
        r.ch = ch; r.avg = 0; r.mx = 0; r.trend = 0; r.cnt = 0;
        if (clr) begin
            fill[ch] = 0;
            wptr[ch] = 0;
            return r;
        end
        if (ok)
            v = smp;
        else if (fill[ch] > 0)
            v = hist[ch][(wptr[ch] + HISTORY_DEPTH - 1) % HISTORY_DEPTH];
        else
            v = 16'd0;
        hist[ch][wptr[ch]] = v;
        wptr[ch] = (wptr[ch] + 1) % HISTORY_DEPTH;
        if (fill[ch] < HISTORY_DEPTH)
            fill[ch]++;
        n = fill[ch];
        oldest = (wptr[ch] + HISTORY_DEPTH - n) % HISTORY_DEPTH;
        sum = 0;
        for (i = 0; i < n; i++) begin
            v = hist[ch][(oldest + i) % HISTORY_DEPTH];
            sum += v;
            if (v > r.mx)
                r.mx = v;
        end
        r.avg = 16'(sum / n);
        r.cnt = 5'(n);
        if (n >= 4) begin
            w = (n / 2 > 3) ? 3 : n / 2;
            olds = 0;
            recents = 0;
            for (i = 0; i < w; i++) begin
                olds += hist[ch][(oldest + i) % HISTORY_DEPTH];
                recents += hist[ch][(oldest + n - w + i) % HISTORY_DEPTH];
            end
            if (olds != 0) begin
                q = ((recents - olds) * TREND_SCALE) / olds;
                if (q > TREND_MAX)
                    q = TREND_MAX;
                r.trend = 32'(q);
            end
        end
        return r;
    endfunction

    function automatic void store_expected(stats_t e);
        exp_fifo[exp_wr % 64] = e;
        exp_wr++;
    endfunction

    // valid is dropped before the next request raises it, so the two fall on different edges
    task automatic send_request(logic [2:0] ch, logic [15:0] smp, logic ok, logic clr);
        @(posedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(posedge clk);
        channel       <= ch;
        sample        <= smp;
        reading_ok    <= ok;
        clear_channel <= clr;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic report_mismatch(stats_t e);
        errors++;
        if (errors <= 10)
            $display({"mismatch at %0t: exp ch=%0d avg=%0d max=%0d trend=%0d cnt=%0d,",
                      " got ch=%0d avg=%0d max=%0d trend=%0d cnt=%0d"},
                     $time, e.ch, e.avg, e.mx, e.trend, e.cnt,
                     channel_out, average, maximum, trend_q8, stored_count);
    endtask

    // output side: stall, compare with oldest expectation
    always @(posedge clk)
    begin
        stats_t e;
        if (out_valid && out_ready) begin
            if (exp_wr == exp_rd) begin
                e = '{default: 0};
                report_mismatch(e);
            end else begin
                e = exp_fifo[exp_rd % 64];
                exp_rd++;
                if (channel_out !== e.ch || average !== e.avg || maximum !== e.mx ||
                    trend_q8 !== e.trend || stored_count !== e.cnt)
                    report_mismatch(e);
            end
        end
        out_ready <= rst_n && !hold_off && $urandom_range(99) >= recv_stall_pct;
    end

    // table rows with typed expectations where obvious
    row_t directed [22] = '{
        '{3'd0, 16'd0,     1'b0, 1'b0, 1, 16'd0,     16'd0,     0, 5'd1},
        '{3'd1, 16'hFFFF,  1'b1, 1'b0, 1, 16'hFFFF,  16'hFFFF,  0, 5'd1},
        '{3'd1, 16'd0,     1'b0, 1'b0, 1, 16'hFFFF,  16'hFFFF,  0, 5'd2},
        '{3'd1, 16'd5,     1'b1, 1'b1, 1, 16'd0,     16'd0,     0, 5'd0},
        '{3'd7, 16'd100,   1'b1, 1'b0, 1, 16'd100,   16'd100,   0, 5'd1},
        '{3'd7, 16'd100,   1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd7, 16'd200,   1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd7, 16'd300,   1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd7, 16'd50,    1'b0, 1'b0, 0, 0, 0, 0, 0},
        '{3'd2, 16'd0,     1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd2, 16'd0,     1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd2, 16'hFFFF,  1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd2, 16'hFFFF,  1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd3, 16'd1,     1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd3, 16'd1,     1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd3, 16'hFFFF,  1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd3, 16'hFFFF,  1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd4, 16'hAAAA,  1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd4, 16'h5555,  1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd4, 16'h5555,  1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd4, 16'h0001,  1'b1, 1'b0, 0, 0, 0, 0, 0},
        '{3'd3, 16'd0,     1'b0, 1'b1, 1, 16'd0,     16'd0,     0, 5'd0}
    };

    task automatic issue(logic [2:0] ch, logic [15:0] smp, logic ok, logic clr);
        store_expected(window_stats(ch, smp, ok, clr));
        send_request(ch, smp, ok, clr);
    endtask

    initial
    begin
        stats_t e;
        int ph, k, cmax, r;
        logic [2:0] ch;
        logic [15:0] smp;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            fill[c] = 0;
            wptr[c] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) begin
            e = window_stats(directed[i].ch, directed[i].smp, directed[i].ok,
                             directed[i].clr);
            if (directed[i].typed)
                e = '{directed[i].ch, directed[i].avg, directed[i].mx,
                      directed[i].trend, directed[i].cnt};
            store_expected(e);
            send_request(directed[i].ch, directed[i].smp, directed[i].ok,
                         directed[i].clr);
        end
        // fill channel 5 to depth so the circular wrap is exercised
        for (k = 0; k < 20; k++)
            issue(3'd5, 16'(k * 3000), 1'b1, 1'b0);

        // long hold-off on the receiver while further requests wait for in_ready
        hold_off <= 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off <= 1'b0;
            end
            for (k = 0; k < 4; k++)
                issue(3'(k), 16'(k), 1'b1, 1'b0);
        join

        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 68 : 24) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 68 : 24) : 0;
            if (ph == 0) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            for (k = 0; k < 280; k++) begin
                r = $urandom_range(99);
                ch = 3'($urandom_range(7));
                // mostly small ranges so trend saturation and zero windows occur
                case ($urandom_range(3))
                    0: smp = 16'($urandom);
                    1: smp = 16'($urandom_range(3));
                    2: smp = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
                    default: smp = 16'($urandom_range(1000));
                endcase
                if (r < 4)
                    issue(ch, smp, 1'($urandom), 1'b1);
                else if (r < 14)
                    issue(ch, smp, 1'b0, 1'b0);
                else
                    issue(ch, smp, 1'b1, 1'b0);
            end
        end

        cmax = 0;
        while (exp_wr != exp_rd && cmax < 200000) begin
            @(posedge clk);
            cmax++;
        end
        repeat (200) @(posedge clk);
        if (errors == 0 && exp_wr == exp_rd)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/sws_pkg.sv
rtl/sws_divider.sv
rtl/sensor_window_statistics.sv
rtl/sws_checker.sv
verif/sensor_window_statistics_test.sv
